// File: sv/nlc_pkg.sv
// Shared types, character codes and class codes for the numeric literal classifier.
// No dependencies; compiled first.
package nlc_pkg;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_QUOTE   = 8'h27;

    typedef enum logic [2:0] {
        CLS_INVALID  = 3'd0,
        CLS_INTEGER  = 3'd1,
        CLS_DECIMAL  = 3'd2,
        CLS_FRACTION = 3'd3,
        CLS_COMPLEX  = 3'd4,
        CLS_QUOTED   = 3'd5
    } t_class;

    // kind of one part: none, integer, decimal, fraction
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_INTEGER  = 2'd1,
        KIND_DECIMAL  = 2'd2,
        KIND_FRACTION = 2'd3
    } t_kind;

    localparam logic [1:0] LEN_SAT = 2'd3;

    typedef struct packed {
        t_kind      kind;
        logic       has_sep;
        logic       has_minus;
        logic       bad;
        logic [1:0] len;
        logic       first_ss;
    } t_part_status;

    typedef struct packed {
        logic feed;
        logic clear;
    } t_part_ctl;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    function automatic t_kind part_value(input t_part_status s);
        t_kind v;
        v = s.kind;
        if (s.bad) begin
            v = KIND_NONE;
        end else if (s.len == 2'd1 && s.first_ss) begin
            v = KIND_NONE;
        end
        return v;
    endfunction

endpackage

// File: sv/nlc_if.sv
// Valid/ready channel interfaces for the classifier: character words in, class words out.
// Depends on nothing beyond the language.
interface nlc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nlc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_class;

    modport source (output valid, output token_class, input ready);
    modport sink   (input valid, input token_class, output ready);
endinterface

// File: sv/nlc_in_stage.sv
// Input register stage: captures one character word per handshake.
// Depends on nlc_pkg and nlc_in_if.
module nlc_in_stage
    import nlc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    nlc_in_if.sink    i_in,
    input  logic      i_take,
    output logic      o_valid,
    output t_in_word  o_word
);

    logic     r_valid;
    t_in_word r_word;

    // free when empty or when the held word moves on this cycle
    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_word.char_code <= i_in.char_code;
            r_word.last_char <= i_in.last_char;
        end
    end

endmodule

// File: sv/nlc_part.sv
// Tracker for one part of a token: kind, separator and sign flags, saturating length.
// Depends on nlc_pkg. Output shows the status including the current character.
module nlc_part
    import nlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_part_ctl    i_ctl,
    input  logic [7:0]   i_char,
    output t_part_status o_status
);

    t_part_status r_status;
    t_part_status n_status;

    always_comb begin
        n_status = r_status;
        if (i_ctl.feed) begin
            if (r_status.len == 2'd0) begin
                n_status.first_ss = (i_char == CH_SLASH) || (i_char == CH_MINUS);
            end
            if (r_status.len != LEN_SAT) begin
                n_status.len = r_status.len + 2'd1;
            end
            if (i_char inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
                if (r_status.kind == KIND_NONE) begin
                    n_status.kind = KIND_INTEGER;
                end
            end else if (i_char == CH_SLASH || i_char == CH_DOT) begin
                if (r_status.has_sep) begin
                    n_status.bad = 1'b1;
                end else begin
                    n_status.has_sep = 1'b1;
                    n_status.kind    = (i_char == CH_SLASH) ? KIND_FRACTION : KIND_DECIMAL;
                end
            end else if (i_char == CH_MINUS) begin
                if (r_status.has_minus) begin
                    n_status.bad = 1'b1;
                end else begin
                    n_status.has_minus = 1'b1;
                end
            end else begin
                n_status.bad = 1'b1;
            end
        end
    end

    assign o_status = n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_status <= '0;
        end else begin
            r_status <= n_status;
        end
    end

endmodule

// File: sv/numeric_literal_classifier.sv
// Top level of the numeric literal classifier: input stage, two part trackers, class register.
// Depends on nlc_pkg, nlc_if, nlc_in_stage and nlc_part.
//
// Characters stream in one word per clock; the word flagged last_char yields one class word
// (0 invalid, 1 integer, 2 decimal, 3 fraction, 4 two-part complex, 5 quoted); the word is held
// in the input register, and its class is then registered in the class register.
// Sustained rate is one character per clock. Only a finished class left untaken stalls
// the stream, and then only when the next last character reaches the classifier; other
// characters keep flowing. No reset sweep: the block takes words straight after reset.
module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    nlc_in_if.sink     i_in,
    nlc_out_if.source  o_out
);

    logic         in_valid;
    t_in_word     in_word;
    logic         fire;
    logic         is_dollar;

    logic         r_at_start;
    logic         r_open_quote;
    logic         r_split;
    logic         n_open_quote;
    logic         n_split;

    t_part_ctl    ctl0;
    t_part_ctl    ctl1;
    t_part_status st0;
    t_part_status st1;

    t_class       cls;
    logic         r_out_valid;
    t_class       r_out_class;

    nlc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    // a last word needs room in the class register; others always proceed
    assign fire = in_valid && (!in_word.last_char || !r_out_valid || o_out.ready);

    assign is_dollar    = (in_word.char_code == CH_DOLLAR);
    assign n_open_quote = r_at_start ? (in_word.char_code == CH_QUOTE) : r_open_quote;
    assign n_split      = r_split || is_dollar;

    assign ctl0.feed  = fire && !is_dollar && !r_split;
    assign ctl1.feed  = fire && !is_dollar && r_split;
    assign ctl0.clear = fire && in_word.last_char;
    assign ctl1.clear = fire && in_word.last_char;

    nlc_part u_part0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl0),
        .i_char   (in_word.char_code),
        .o_status (st0)
    );

    nlc_part u_part1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl1),
        .i_char   (in_word.char_code),
        .o_status (st1)
    );

    always_comb begin
        if (n_open_quote && in_word.char_code == CH_QUOTE) begin
            cls = CLS_QUOTED;
        end else if (!n_split) begin
            cls = t_class'({1'b0, part_value(st0)});
        end else if (part_value(st0) != KIND_NONE && part_value(st1) != KIND_NONE) begin
            cls = CLS_COMPLEX;
        end else begin
            cls = CLS_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_open_quote <= 1'b0;
            r_split      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                if (in_word.last_char) begin
                    r_at_start   <= 1'b1;
                    r_open_quote <= 1'b0;
                    r_split      <= 1'b0;
                end else begin
                    r_at_start   <= 1'b0;
                    r_open_quote <= n_open_quote;
                    r_split      <= n_split;
                end
            end
            if (fire && in_word.last_char) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire && in_word.last_char) begin
            r_out_class <= cls;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.token_class = r_out_class;

    // token state is back at its start after a last word
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && in_word.last_char |=> r_at_start && !r_split && !r_open_quote)
        else $error("token state not cleared after last word");

    // a split cannot be pending before the first character
    a_split_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> !r_split)
        else $error("split flag set at token start");

    // a new class never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && in_word.last_char && r_out_valid |-> o_out.ready)
        else $error("class register overwritten");

    // class codes stay within the defined set
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_class <= CLS_QUOTED)
        else $error("class code out of range");

endmodule
